FILE: rtl/cst_pkg.sv
package cst_pkg;

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_STRING,
        M_EQ,
        M_LT,
        M_GT,
        M_BANG
    } t_mode;

    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_NUMBER  = 5'd2;
    localparam logic [4:0] K_STRING  = 5'd3;
    localparam logic [4:0] K_KW_BASE = 5'd4;
    localparam logic [4:0] K_PLUS    = 5'd11;
    localparam logic [4:0] K_MINUS   = 5'd12;
    localparam logic [4:0] K_STAR    = 5'd13;
    localparam logic [4:0] K_SLASH   = 5'd14;
    localparam logic [4:0] K_ASSIGN  = 5'd15;
    localparam logic [4:0] K_EQ_EQ   = 5'd16;
    localparam logic [4:0] K_NOT_EQ  = 5'd17;
    localparam logic [4:0] K_LESS    = 5'd18;
    localparam logic [4:0] K_GREATER = 5'd19;
    localparam logic [4:0] K_LESS_EQ = 5'd20;
    localparam logic [4:0] K_GR_EQ   = 5'd21;
    localparam logic [4:0] K_SEMI    = 5'd22;
    localparam logic [4:0] K_COMMA   = 5'd23;
    localparam logic [4:0] K_LPAREN  = 5'd24;
    localparam logic [4:0] K_RPAREN  = 5'd25;
    localparam logic [4:0] K_LBRACE  = 5'd26;
    localparam logic [4:0] K_RBRACE  = 5'd27;
    localparam logic [4:0] K_LBRACK  = 5'd28;
    localparam logic [4:0] K_RBRACK  = 5'd29;
    localparam logic [4:0] K_UNKNOWN = 5'd30;

    localparam logic [7:0] C_LF = 8'd10;

    localparam int unsigned NUM_KW = 7;

    localparam logic [7:0] KW_TEXT [NUM_KW][6] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n"},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"m", "a", "i", "n", 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4};

    typedef struct packed {
        logic [4:0]         kind;
        logic signed [31:0] value;
        logic [7:0]         length;
        logic [15:0]        line;
        logic [15:0]        column;
        logic               last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_lex_out;

    // len is the stored length clipped to 7, which matches no keyword
    function automatic logic [4:0] ident_kind(input logic [5:0][7:0] chars,
                                              input logic [2:0] len);
        logic [4:0] kind;
        logic       same;
        kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            same = (len == KW_LEN[k]);
            for (int i = 0; i < 6; i++) begin
                if ((3'(i) < KW_LEN[k]) && (chars[i] != KW_TEXT[k][i])) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                kind = K_KW_BASE + 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] kind;
        unique case (c)
            "+":     kind = K_PLUS;
            "-":     kind = K_MINUS;
            "*":     kind = K_STAR;
            "/":     kind = K_SLASH;
            ";":     kind = K_SEMI;
            ",":     kind = K_COMMA;
            "(":     kind = K_LPAREN;
            ")":     kind = K_RPAREN;
            "{":     kind = K_LBRACE;
            "}":     kind = K_RBRACE;
            "[":     kind = K_LBRACK;
            "]":     kind = K_RBRACK;
            default: kind = K_UNKNOWN;
        endcase
        return kind;
    endfunction

    function automatic t_token make_token(input logic [4:0] kind,
                                          input logic [31:0] value,
                                          input logic [7:0] length,
                                          input logic [15:0] line,
                                          input logic [15:0] column);
        t_token t;
        t.kind   = kind;
        t.value  = value;
        t.length = length;
        t.line   = line;
        t.column = column;
        t.last   = 1'b0;
        return t;
    endfunction

endpackage

FILE: rtl/cst_lexer.sv
module cst_lexer #(
    parameter int unsigned     MAX_TOKEN_LENGTH = 255,
    parameter longint unsigned MAX_LINE         = 65535
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_char_code,
    input  logic                i_end_of_input,
    output cst_pkg::t_lex_out   o_result
);

    localparam int RW  = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int LW  = $clog2(MAX_LINE + 1);
    localparam int RWX = (RW > 8) ? RW : 8;
    localparam int LWX = (LW > 16) ? LW : 16;

    cst_pkg::t_mode   r_mode, n_mode;
    logic [5:0][7:0]  r_kw, n_kw;
    logic [RW-1:0]    r_run, n_run;
    logic [31:0]      r_accum, n_accum;
    logic [LW-1:0]    r_line, n_line;
    logic [15:0]      r_col, n_col;
    logic [15:0]      r_start, n_start;

    logic [7:0]       c;
    logic             is_alpha, is_digit, is_ws;
    logic [31:0]      digit;
    logic [LW-1:0]    adv_line;
    logic [15:0]      adv_col;
    logic [RW-1:0]    run_inc;
    logic [RWX-1:0]   run_x;
    logic [LWX-1:0]   line_x;
    logic [7:0]       len8;
    logic [15:0]      line16;
    logic [2:0]       kw_len;
    logic [2:0]       kw_idx;
    cst_pkg::t_token  fl_tok, single_tok, tok_a, tok_b;
    logic             fl_valid, single_valid, a_valid, b_valid, do_begin;

    assign c        = i_char_code;
    assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    assign is_digit = (c >= "0") && (c <= "9");
    assign is_ws    = (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == cst_pkg::C_LF);
    assign digit    = 32'(c - "0");

    assign adv_line = ((c == cst_pkg::C_LF) && (r_line < LW'(MAX_LINE))) ? r_line + 1'b1 : r_line;
    assign adv_col  = (c == cst_pkg::C_LF) ? 16'd1 :
                      ((r_col != 16'hFFFF) ? r_col + 16'd1 : r_col);
    assign run_inc  = (r_run < RW'(MAX_TOKEN_LENGTH)) ? r_run + 1'b1 : r_run;

    assign run_x  = RWX'(r_run);
    assign line_x = LWX'(r_line);
    assign len8   = (run_x > RWX'(255)) ? 8'hFF : run_x[7:0];
    assign line16 = (line_x > LWX'(65535)) ? 16'hFFFF : line_x[15:0];
    assign kw_len = (r_run < RW'(7)) ? r_run[2:0] : 3'd7;
    assign kw_idx = r_run[2:0];

    // token pending in the current mode
    always_comb begin
        fl_valid = 1'b1;
        fl_tok   = cst_pkg::make_token(cst_pkg::K_UNKNOWN, 32'd0, 8'd1, line16, r_start);
        unique case (r_mode)
            cst_pkg::M_IDENT:  fl_tok = cst_pkg::make_token(cst_pkg::ident_kind(r_kw, kw_len),
                                                            32'd0, len8, line16, r_start);
            cst_pkg::M_NUMBER: fl_tok = cst_pkg::make_token(cst_pkg::K_NUMBER, r_accum, len8,
                                                            line16, r_start);
            cst_pkg::M_STRING: fl_tok = cst_pkg::make_token(cst_pkg::K_STRING, 32'd0, len8,
                                                            line16, r_start);
            cst_pkg::M_EQ:     fl_tok.kind = cst_pkg::K_ASSIGN;
            cst_pkg::M_LT:     fl_tok.kind = cst_pkg::K_LESS;
            cst_pkg::M_GT:     fl_tok.kind = cst_pkg::K_GREATER;
            cst_pkg::M_BANG:   fl_tok.kind = cst_pkg::K_UNKNOWN;
            default:           fl_valid = 1'b0;
        endcase
    end

    assign single_tok = cst_pkg::make_token(cst_pkg::single_kind(c), 32'd0, 8'd1, line16, r_col);

    always_comb begin
        n_mode       = r_mode;
        n_kw         = r_kw;
        n_run        = r_run;
        n_accum      = r_accum;
        n_line       = r_line;
        n_col        = r_col;
        n_start      = r_start;
        tok_a        = fl_tok;
        tok_b        = single_tok;
        a_valid      = 1'b0;
        b_valid      = 1'b0;
        do_begin     = 1'b0;
        single_valid = 1'b0;

        if (i_end_of_input) begin
            a_valid = fl_valid;
            tok_b   = cst_pkg::make_token(cst_pkg::K_EOF, 32'd0, 8'd0, line16, r_col);
            b_valid = 1'b1;
            n_mode  = cst_pkg::M_IDLE;
        end else begin
            unique case (r_mode)
                cst_pkg::M_IDENT: begin
                    if (is_alpha || is_digit) begin
                        if (r_run < RW'(6)) begin
                            n_kw[kw_idx] = c;
                        end
                        n_run  = run_inc;
                        n_line = adv_line;
                        n_col  = adv_col;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                cst_pkg::M_NUMBER: begin
                    if (is_digit) begin
                        n_accum = (r_accum << 3) + (r_accum << 1) + digit;
                        n_run   = run_inc;
                        n_line  = adv_line;
                        n_col   = adv_col;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                cst_pkg::M_STRING: begin
                    if (c == "\"") begin
                        a_valid = 1'b1;
                        n_mode  = cst_pkg::M_IDLE;
                    end else begin
                        n_run = run_inc;
                    end
                    n_line = adv_line;
                    n_col  = adv_col;
                end
                cst_pkg::M_EQ, cst_pkg::M_LT, cst_pkg::M_GT, cst_pkg::M_BANG: begin
                    if (c == "=") begin
                        tok_a        = fl_tok;
                        tok_a.length = 8'd2;
                        unique case (r_mode)
                            cst_pkg::M_EQ: tok_a.kind = cst_pkg::K_EQ_EQ;
                            cst_pkg::M_LT: tok_a.kind = cst_pkg::K_LESS_EQ;
                            cst_pkg::M_GT: tok_a.kind = cst_pkg::K_GR_EQ;
                            default:       tok_a.kind = cst_pkg::K_NOT_EQ;
                        endcase
                        a_valid = 1'b1;
                        n_mode  = cst_pkg::M_IDLE;
                        n_line  = adv_line;
                        n_col   = adv_col;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                default: do_begin = 1'b1;
            endcase
        end

        // close the pending token, then start a new one with this byte
        if (do_begin) begin
            a_valid = fl_valid;
            n_start = r_col;
            n_run   = '0;
            n_line  = adv_line;
            n_col   = adv_col;
            n_mode  = cst_pkg::M_IDLE;
            if (is_ws) begin
                n_mode = cst_pkg::M_IDLE;
            end else if (is_alpha) begin
                n_mode = cst_pkg::M_IDENT;
                n_kw   = '0;
                n_kw[0] = c;
                n_run  = RW'(1);
            end else if (is_digit) begin
                n_mode  = cst_pkg::M_NUMBER;
                n_accum = digit;
                n_run   = RW'(1);
            end else if (c == "\"") begin
                n_mode = cst_pkg::M_STRING;
            end else if (c == "=") begin
                n_mode = cst_pkg::M_EQ;
            end else if (c == "<") begin
                n_mode = cst_pkg::M_LT;
            end else if (c == ">") begin
                n_mode = cst_pkg::M_GT;
            end else if (c == "!") begin
                n_mode = cst_pkg::M_BANG;
            end else begin
                single_valid = 1'b1;
            end
            b_valid = single_valid;
        end
    end

    always_comb begin
        o_result = '0;
        if (a_valid) begin
            o_result.tok0      = tok_a;
            o_result.tok0.last = !b_valid;
            o_result.tok1      = tok_b;
            o_result.tok1.last = 1'b1;
            o_result.count     = b_valid ? 2'd2 : 2'd1;
        end else begin
            o_result.tok0      = tok_b;
            o_result.tok0.last = 1'b1;
            o_result.tok1      = tok_b;
            o_result.count     = b_valid ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cst_pkg::M_IDLE;
            r_kw    <= '0;
            r_run   <= '0;
            r_accum <= '0;
            r_line  <= LW'(1);
            r_col   <= 16'd1;
            r_start <= 16'd1;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_kw    <= n_kw;
            r_run   <= n_run;
            r_accum <= n_accum;
            r_line  <= n_line;
            r_col   <= n_col;
            r_start <= n_start;
        end
    end

endmodule

FILE: rtl/c_subset_tokenizer_top.sv
// a token word enters the output queue when the byte that ends it is accepted
// throughput: one byte per cycle unless stalled; a byte yielding two tokens writes two
// words into the four-word output queue; input stalls while three or more words wait
// reset: synchronous, active low; idle mode, line and column 1, output queue empty
module c_subset_tokenizer_top #(
    parameter int unsigned     MAX_TOKEN_LENGTH = 255,
    parameter longint unsigned MAX_LINE         = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_end_of_input,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [4:0]         o_token_kind,
    output logic signed [31:0] o_number_value,
    output logic [7:0]         o_token_length,
    output logic [15:0]        o_line_number,
    output logic [15:0]        o_column_number,
    output logic               o_last_of_run
);

    logic              in_accept;
    logic              pop;
    cst_pkg::t_lex_out lex;
    cst_pkg::t_token   r_fifo [4];
    cst_pkg::t_token   head;
    logic [1:0]        r_wr, r_rd;
    logic [2:0]        r_count;
    logic [1:0]        push_n;

    assign o_in_stall  = (r_count > 3'd2);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != 3'd0);
    assign pop         = o_out_valid && !i_out_stall;
    assign push_n      = in_accept ? lex.count : 2'd0;

    cst_lexer #(
        .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH),
        .MAX_LINE(MAX_LINE)
    ) u_lexer (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(in_accept),
        .i_char_code(i_char_code),
        .i_end_of_input(i_end_of_input),
        .o_result(lex)
    );

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr] <= lex.tok0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr + 2'd1] <= lex.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + push_n;
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= r_count + {1'b0, push_n} - {2'b00, pop};
        end
    end

    assign head            = r_fifo[r_rd];
    assign o_token_kind    = head.kind;
    assign o_number_value  = head.value;
    assign o_token_length  = head.length;
    assign o_line_number   = head.line;
    assign o_column_number = head.column;
    assign o_last_of_run   = head.last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("output queue overflow");

    a_eof_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_token_kind == cst_pkg::K_EOF)) |-> o_last_of_run)
        else $error("eof word not last of run");

    a_value_only_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_token_kind != cst_pkg::K_NUMBER)) |-> (o_number_value == 32'sd0))
        else $error("nonzero value on non-number token");

    a_eoi_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_end_of_input) |=> (r_count != 3'd0))
        else $error("end of input produced no word");

endmodule
